// File: rtl/debug_packet_receiver_assert.svh
// assertion macros for the debug packet receiver
// expects clk and rst in the scope of the module that uses them
`ifndef DEBUG_PACKET_RECEIVER_ASSERT_SVH
`define DEBUG_PACKET_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define DPR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define DPR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPR_ASSERT(name, prop, msg)
`define DPR_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: rtl/dbgrx_pkg.sv
// shared types, constants and helpers of the debug packet receiver
// no dependencies
package dbgrx_pkg;

  localparam int BUF_DEPTH_DEF = 512;

  localparam int RX_TDATA_W = 24;
  localparam int TX_TDATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int LEN_W      = 9;
  localparam int MAXLEN_W   = 10;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = 2;
  localparam int JOBQ_CNT_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CHAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NAK_CHAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 3'd4;

  // request types on the input
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // result kinds on the output
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [6:0] SEQ_SEP = 7'h3a;

  typedef enum logic [1:0] {
    JOB_READ,
    JOB_NAK,
    JOB_ACK,
    JOB_ACK_SEQ
  } job_kind_t;

  // one queued response, expands to one to four output beats
  typedef struct packed {
    job_kind_t         kind;
    logic [7:0]        first;
    logic [6:0]        seq0;
    logic [6:0]        seq1;
    logic [LEN_W-1:0]  len;
  } job_t;

  // hex digit value, 5-bit two's complement, all ones when not a digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h1f;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = 5'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

// File: rtl/dbgrx_emit.sv
// response queue and beat sequencer of the debug packet receiver
// depends on dbgrx_pkg and debug_packet_receiver_assert.svh
`include "debug_packet_receiver_assert.svh"

module dbgrx_emit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  dbgrx_pkg::job_t                   job,
  output logic [dbgrx_pkg::JOBQ_CNT_W-1:0]  count,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dbgrx_pkg::TX_TDATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);

  dbgrx_pkg::job_t                  q [dbgrx_pkg::JOBQ_DEPTH];
  logic [dbgrx_pkg::JOBQ_PTR_W-1:0] wr_ptr;
  logic [dbgrx_pkg::JOBQ_PTR_W-1:0] rd_ptr;
  logic [1:0]                       beat;
  logic [1:0]                       last_beat;
  dbgrx_pkg::job_t                  head;
  logic [7:0]                       o_byte;
  logic [dbgrx_pkg::LEN_W-1:0]      o_len;
  logic [1:0]                       o_kind;
  logic                             fire;
  logic                             pop;

  assign head          = q[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign fire          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tlast  = (beat == last_beat);
  assign pop           = fire && m_axis_tlast;

  always_comb begin
    last_beat = 2'd0;
    o_kind    = dbgrx_pkg::KIND_TX;
    o_byte    = head.first;
    o_len     = '0;
    case (head.kind)
      dbgrx_pkg::JOB_READ: begin
        o_kind = dbgrx_pkg::KIND_READ;
      end
      dbgrx_pkg::JOB_NAK: begin
        o_kind = dbgrx_pkg::KIND_TX;
      end
      dbgrx_pkg::JOB_ACK: begin
        last_beat = 2'd1;
        if (beat != 2'd0) begin
          o_kind = dbgrx_pkg::KIND_ACCEPT;
          o_byte = '0;
          o_len  = head.len;
        end
      end
      dbgrx_pkg::JOB_ACK_SEQ: begin
        last_beat = 2'd3;
        case (beat)
          2'd0: o_byte = head.first;
          2'd1: o_byte = {1'b0, head.seq0};
          2'd2: o_byte = {1'b0, head.seq1};
          default: begin
            o_kind = dbgrx_pkg::KIND_ACCEPT;
            o_byte = '0;
            o_len  = head.len;
          end
        endcase
      end
      default: begin
        o_kind = dbgrx_pkg::KIND_TX;
      end
    endcase
  end

  // tdata: out_byte [7:0], packet_len [16:8], zero pad
  assign m_axis_tdata = {{(dbgrx_pkg::TX_TDATA_W - 8 - dbgrx_pkg::LEN_W){1'b0}}, o_len, o_byte};
  assign m_axis_tuser = o_kind;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      beat   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (fire) begin
        beat <= m_axis_tlast ? 2'd0 : beat + 2'd1;
      end
      count <= count + dbgrx_pkg::JOBQ_CNT_W'(push) - dbgrx_pkg::JOBQ_CNT_W'(pop);
    end
  end

  `DPR_ASSERT(a_count_cap, count <= dbgrx_pkg::JOBQ_DEPTH, "job queue count beyond depth")
  `DPR_ASSERT(a_push_room, push && (count == dbgrx_pkg::JOBQ_DEPTH) |-> pop, "push into full queue")
  `DPR_ASSERT(a_beat_range, (count != '0) |-> (beat <= last_beat), "beat index past job end")

endmodule

// File: rtl/debug_packet_receiver.sv
// debug packet receiver top level: byte parser, payload store, read-back
// depends on dbgrx_pkg, dbgrx_emit and debug_packet_receiver_assert.svh
//
//   port group   dir  beat contents
//   s_axis_*     in   serial byte or payload read request
//   m_axis_*     out  byte to send, packet accepted report, or read data
//   cfg_*        in   register write, index 0..4, no read-back
//
// one input beat per cycle while s_axis_tready is high; a parser step and a store access per beat
// the payload store is a single-port-write, registered-read memory; read
//   data lands in the next cycle in a stage that pushes into a 4-deep job queue
// a packet end with a good checksum yields up to four output beats, sent one per cycle
//   while m_axis_tready is high; input stalls while four jobs wait in the stage and queue
// rst is synchronous; the store has no clearing pass and is ready at once
`include "debug_packet_receiver_assert.svh"

module debug_packet_receiver #(
  parameter int BUF_DEPTH = dbgrx_pkg::BUF_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // serial input and read requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dbgrx_pkg::RX_TDATA_W-1:0]    s_axis_tdata,  // rx_byte [7:0], read_index [16:8]
  input  logic [0:0]                          s_axis_tuser,  // req_type [0]
  // responses
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dbgrx_pkg::TX_TDATA_W-1:0]    m_axis_tdata,  // out_byte [7:0], packet_len [16:8]
  output logic [1:0]                          m_axis_tuser,  // out_kind [1:0]
  output logic                                m_axis_tlast,
  // configuration
  input  logic                                cfg_we,
  input  logic [dbgrx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dbgrx_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int CMP_W = (CNT_W > dbgrx_pkg::MAXLEN_W) ? CNT_W : dbgrx_pkg::MAXLEN_W;
  localparam int PW    = ((AW > 10) ? AW : 10) + 1;
  localparam int LEN_MAX = (1 << dbgrx_pkg::LEN_W) - 1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_DATA,
    PH_HIGH,
    PH_LOW
  } phase_t;

  // configuration registers
  logic [7:0]                         start_char;
  logic [7:0]                         end_char;
  logic [7:0]                         ack_char;
  logic [7:0]                         nak_char;
  logic [dbgrx_pkg::MAXLEN_W-1:0]     max_len;

  // parser state
  phase_t                             phase;
  logic [7:0]                         running_sum;
  logic [CNT_W-1:0]                   stored_count;
  logic [4:0]                         high_digit;
  logic [CNT_W-1:0]                   accepted_len;
  logic                               seq_drop;     // payload starts at offset 3
  logic [6:0]                         byte0;
  logic [6:0]                         byte1;
  logic [6:0]                         byte2;

  // payload store
  logic [6:0]                         mem [BUF_DEPTH];
  logic [6:0]                         mem_q;
  logic [AW-1:0]                      rd_addr;
  logic                               wr_en;

  // input beat fields
  logic                               req_type;
  logic [7:0]                         rx_byte;
  logic [8:0]                         read_index;
  logic                               s_fire;

  // decode
  logic                               at_limit;
  logic [4:0]                         lo_digit;
  logic [9:0]                         expected;
  logic                               sum_match;
  logic                               seq_hit;
  logic [CNT_W-1:0]                   len_full;
  logic [dbgrx_pkg::LEN_W-1:0]        len_sat;
  logic [PW-1:0]                      rd_pos;
  logic                               rd_ok;
  logic                               new_push;
  dbgrx_pkg::job_t                    new_job;

  // read stage between store and job queue
  logic                               a_valid;
  logic                               a_rd_ok;
  dbgrx_pkg::job_t                    a_job;
  dbgrx_pkg::job_t                    push_job;
  logic [dbgrx_pkg::JOBQ_CNT_W-1:0]   q_count;

  assign req_type   = s_axis_tuser[0];
  assign rx_byte    = s_axis_tdata[7:0];
  assign read_index = s_axis_tdata[16:8];

  // room for this beat's job even if the stage ahead also pushes
  assign s_axis_tready = (dbgrx_pkg::JOBQ_CNT_W'(q_count) + dbgrx_pkg::JOBQ_CNT_W'(a_valid))
                         < dbgrx_pkg::JOBQ_CNT_W'(dbgrx_pkg::JOBQ_DEPTH);
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // store limit is min(max_len, BUF_DEPTH)
  assign at_limit = (CMP_W'(stored_count) >= CMP_W'(max_len)) ||
                    (CMP_W'(stored_count) >= CMP_W'(BUF_DEPTH));

  // checksum: sum == 16*high + low with invalid digits as -1
  assign lo_digit  = dbgrx_pkg::hex_value(rx_byte);
  assign expected  = {high_digit[4], high_digit, 4'b0000} + {{5{lo_digit[4]}}, lo_digit};
  assign sum_match = ({2'b00, running_sum} == expected);

  // sequence id present when byte 2 of a packet of three or more is ':'
  assign seq_hit  = (CMP_W'(stored_count) >= CMP_W'(3)) && (byte2 == dbgrx_pkg::SEQ_SEP);
  assign len_full = seq_hit ? stored_count - CNT_W'(3) : stored_count;
  assign len_sat  = (CMP_W'(len_full) > CMP_W'(LEN_MAX)) ? dbgrx_pkg::LEN_W'(LEN_MAX)
                                                         : dbgrx_pkg::LEN_W'(len_full);

  // host read address and bounds
  assign rd_pos  = PW'(read_index) + (seq_drop ? PW'(3) : PW'(0));
  assign rd_ok   = (CMP_W'(read_index) < CMP_W'(accepted_len)) && (rd_pos < PW'(BUF_DEPTH));
  assign rd_addr = rd_pos[AW-1:0];

  assign wr_en = s_fire && (req_type == dbgrx_pkg::REQ_BYTE) && (phase == PH_DATA) &&
                 !at_limit && (rx_byte != end_char);

  // which response, if any, this beat produces
  always_comb begin
    new_push      = 1'b0;
    new_job.kind  = dbgrx_pkg::JOB_NAK;
    new_job.first = nak_char;
    new_job.seq0  = byte0;
    new_job.seq1  = byte1;
    new_job.len   = len_sat;
    if (req_type == dbgrx_pkg::REQ_READ) begin
      new_push     = 1'b1;
      new_job.kind = dbgrx_pkg::JOB_READ;
    end else begin
      case (phase)
        PH_DATA: begin
          new_push = at_limit;
        end
        PH_LOW: begin
          new_push = 1'b1;
          if (sum_match) begin
            new_job.kind  = seq_hit ? dbgrx_pkg::JOB_ACK_SEQ : dbgrx_pkg::JOB_ACK;
            new_job.first = ack_char;
          end
        end
        default: begin
          new_push = 1'b0;
        end
      endcase
    end
  end

  // payload store, one write and one registered read per cycle, only on an accepted beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[stored_count[AW-1:0]] <= rx_byte[6:0];
    end
    if (s_fire) begin
      mem_q <= mem[rd_addr];
    end
  end

  // first three payload bytes kept aside for the sequence check and echo
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (stored_count == CNT_W'(0)) begin
        byte0 <= rx_byte[6:0];
      end
      if (stored_count == CNT_W'(1)) begin
        byte1 <= rx_byte[6:0];
      end
      if (stored_count == CNT_W'(2)) begin
        byte2 <= rx_byte[6:0];
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_job   <= new_job;
      a_rd_ok <= rd_ok;
    end
  end

  // parser state machine and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      start_char   <= 8'd36;
      end_char     <= 8'd35;
      ack_char     <= 8'd43;
      nak_char     <= 8'd45;
      max_len      <= 10'd512;
      phase        <= PH_HUNT;
      running_sum  <= '0;
      stored_count <= '0;
      high_digit   <= '0;
      accepted_len <= '0;
      seq_drop     <= 1'b0;
      a_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dbgrx_pkg::REG_START_CHAR: start_char <= cfg_data[7:0];
          dbgrx_pkg::REG_END_CHAR:   end_char   <= cfg_data[7:0];
          dbgrx_pkg::REG_ACK_CHAR:   ack_char   <= cfg_data[7:0];
          dbgrx_pkg::REG_NAK_CHAR:   nak_char   <= cfg_data[7:0];
          dbgrx_pkg::REG_MAX_LEN:    max_len    <= cfg_data;
          default: begin
          end
        endcase
      end
      a_valid <= s_fire && new_push;
      if (s_fire && (req_type == dbgrx_pkg::REQ_BYTE)) begin
        case (phase)
          PH_HUNT: begin
            if (rx_byte == start_char) begin
              phase        <= PH_DATA;
              running_sum  <= '0;
              stored_count <= '0;
              accepted_len <= '0;
              seq_drop     <= 1'b0;
            end
          end
          PH_DATA: begin
            if (at_limit) begin
              phase <= PH_HUNT;
            end else if (rx_byte == end_char) begin
              phase <= PH_HIGH;
            end else begin
              running_sum  <= running_sum + {1'b0, rx_byte[6:0]};
              stored_count <= stored_count + CNT_W'(1);
            end
          end
          PH_HIGH: begin
            high_digit <= lo_digit;
            phase      <= PH_LOW;
          end
          PH_LOW: begin
            phase <= PH_HUNT;
            if (sum_match) begin
              seq_drop     <= seq_hit;
              accepted_len <= len_full;
            end
          end
          default: begin
            phase <= PH_HUNT;
          end
        endcase
      end
    end
  end

  // read data resolves here, zero beyond the accepted length
  always_comb begin
    push_job = a_job;
    if (a_job.kind == dbgrx_pkg::JOB_READ) begin
      push_job.first = a_rd_ok ? {1'b0, mem_q} : 8'd0;
      push_job.len   = '0;
    end
  end

  dbgrx_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .push          (a_valid),
    .job           (push_job),
    .count         (q_count),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `DPR_ASSERT(a_count_cap, stored_count <= BUF_DEPTH, "stored count beyond store depth")
  `DPR_ASSERT(a_len_cap, accepted_len <= stored_count, "accepted length beyond stored count")
  `DPR_ASSERT(a_offset_room, seq_drop |-> (CMP_W'(accepted_len) + CMP_W'(3) <= CMP_W'(stored_count)), "sequence offset past stored data")

endmodule

// File: sim/tb.sv
// testbench for debug_packet_receiver: directed table, then random packet traffic
// checks every output beat against the table's inline results or a cycle-free model of the packet parser
// depends on dbgrx_pkg and the rtl of debug_packet_receiver
module tb;

  // one output beat as the checker sees it
  typedef struct packed {
    logic [1:0]                  kind;
    logic [7:0]                  data;
    logic [dbgrx_pkg::LEN_W-1:0] len;
    logic                        last;
  } beat_t;

  // one row of the directed table; typed rows carry their single result inline
  typedef struct packed {
    logic       req;
    logic [7:0] rx;
    logic [8:0] idx;
    logic       typed;
    beat_t      want;
  } stim_row_t;

  typedef enum logic [1:0] {ST_HUNT, ST_DATA, ST_HIGH, ST_LOW} rx_state_t;
  typedef enum int {CK_GOOD, CK_WRONG, CK_BAD_DIGIT} csum_mode_t;

  localparam beat_t NO_BEAT     = '0;
  localparam int    HOLD_CYCLES = 300;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [dbgrx_pkg::RX_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]                       s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [dbgrx_pkg::TX_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                       m_axis_tuser;
  logic                             m_axis_tlast;
  logic                             cfg_we = 1'b0;
  logic [dbgrx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dbgrx_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  debug_packet_receiver u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // rx_byte [7:0], read_index [16:8]
    .s_axis_tuser  (s_axis_tuser),  // req_type [0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // out_byte [7:0], packet_len [16:8]
    .m_axis_tuser  (m_axis_tuser),  // out_kind [1:0]
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // register copies, reset values
  logic [7:0]                     cfg_start  = 8'h24;
  logic [7:0]                     cfg_end    = 8'h23;
  logic [7:0]                     cfg_ack    = 8'h2b;
  logic [7:0]                     cfg_nak    = 8'h2d;
  logic [dbgrx_pkg::MAXLEN_W-1:0] cfg_maxlen = 10'd512;

  // parser state copy
  rx_state_t         rx_state   = ST_HUNT;
  logic [7:0]        sum8       = '0;
  logic [9:0]        stored_cnt = '0;
  logic signed [4:0] hi_digit   = '0;
  logic [9:0]        acc_len    = '0;
  logic [1:0]        pay_off    = '0;
  logic [6:0]        store_mem [dbgrx_pkg::BUF_DEPTH_DEF];

  beat_t resp_beats[$];    // beats caused by the beat just accepted
  beat_t awaited[$];       // beats still owed by the block
  int    err_count = 0;
  int    snd_idle  = 0;    // percent of cycles the sender idles
  int    rcv_stall = 0;    // percent of cycles the receiver stalls
  int    hold_req  = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  beat_t got_beat, exp_beat;

  // directed table
  stim_row_t dir_rows [30] = '{
    // reads right after reset see an empty store
    '{dbgrx_pkg::REQ_READ, 8'h00, 9'd0,   1'b1, '{dbgrx_pkg::KIND_READ, 8'h00, 9'd0, 1'b1}},
    '{dbgrx_pkg::REQ_READ, 8'h00, 9'd511, 1'b1, '{dbgrx_pkg::KIND_READ, 8'h00, 9'd0, 1'b1}},
    // "12:" prefix, a byte with bit 7 set, start char inside the payload
    '{dbgrx_pkg::REQ_BYTE, 8'h24, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h31, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h32, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h3a, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'hc1, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h24, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h23, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h30, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h32, 9'd0, 1'b0, NO_BEAT},
    // read back behind the sequence prefix, then past the end
    '{dbgrx_pkg::REQ_READ, 8'hff, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_READ, 8'hff, 9'd1, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_READ, 8'hff, 9'd2, 1'b1, '{dbgrx_pkg::KIND_READ, 8'h00, 9'd0, 1'b1}},
    // two-byte packet: the store still holds ':' at byte 2 from before
    '{dbgrx_pkg::REQ_BYTE, 8'h24, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h61, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h62, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h23, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h63, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h33, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_READ, 8'h00, 9'd0, 1'b0, NO_BEAT},
    // bad low digit counts as -1, so sum 0x0f matches high digit 1
    '{dbgrx_pkg::REQ_BYTE, 8'h24, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h0f, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h23, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h31, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h67, 9'd0, 1'b0, NO_BEAT},
    // empty packet with a bad high digit is refused
    '{dbgrx_pkg::REQ_BYTE, 8'h24, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h23, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h7a, 9'd0, 1'b0, NO_BEAT},
    '{dbgrx_pkg::REQ_BYTE, 8'h30, 9'd0, 1'b1, '{dbgrx_pkg::KIND_TX, 8'h2d, 9'd0, 1'b1}}
  };

  function automatic int digit_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
  endfunction

  function automatic void add_beat(input logic [1:0] k, input logic [7:0] d,
                                   input logic [dbgrx_pkg::LEN_W-1:0] l);
    resp_beats.push_back('{k, d, l, 1'b0});
  endfunction

  // parser model: advances the state copy by one beat, fills resp_beats
  function automatic void predict_response(input logic req, input logic [7:0] rx,
                                           input logic [8:0] idx);
    int         lim, hi, lo;
    logic [9:0] pos, len;
    resp_beats.delete();
    lim = (cfg_maxlen < dbgrx_pkg::BUF_DEPTH_DEF) ? int'(cfg_maxlen)
                                                  : dbgrx_pkg::BUF_DEPTH_DEF;
    if (req == dbgrx_pkg::REQ_READ) begin
      pos = idx + pay_off;
      if ({1'b0, idx} < acc_len && pos < dbgrx_pkg::BUF_DEPTH_DEF) begin
        add_beat(dbgrx_pkg::KIND_READ, {1'b0, store_mem[pos[8:0]]}, '0);
      end else begin
        add_beat(dbgrx_pkg::KIND_READ, 8'h00, '0);
      end
    end else begin
      case (rx_state)
        ST_HUNT: begin
          // a new packet drops the previous accepted payload
          if (rx == cfg_start) begin
            rx_state   = ST_DATA;
            sum8       = '0;
            stored_cnt = '0;
            acc_len    = '0;
            pay_off    = '0;
          end
        end
        ST_DATA: begin
          // store full: this byte is eaten, even the end char
          if (stored_cnt >= lim) begin
            add_beat(dbgrx_pkg::KIND_TX, cfg_nak, '0);
            rx_state = ST_HUNT;
          end else if (rx == cfg_end) begin
            rx_state = ST_HIGH;
          end else begin
            store_mem[stored_cnt[8:0]] = rx[6:0];
            sum8       = sum8 + {1'b0, rx[6:0]};
            stored_cnt = stored_cnt + 1'b1;
          end
        end
        ST_HIGH: begin
          hi_digit = 5'(digit_val(rx));
          rx_state = ST_LOW;
        end
        default: begin
          hi       = int'(hi_digit);
          lo       = digit_val(rx);
          rx_state = ST_HUNT;
          if (int'(sum8) == hi * 16 + lo) begin
            len = stored_cnt;
            add_beat(dbgrx_pkg::KIND_TX, cfg_ack, '0);
            // sequence id "xx:" is echoed and stripped
            if (stored_cnt >= 3 && store_mem[2] == dbgrx_pkg::SEQ_SEP) begin
              add_beat(dbgrx_pkg::KIND_TX, {1'b0, store_mem[0]}, '0);
              add_beat(dbgrx_pkg::KIND_TX, {1'b0, store_mem[1]}, '0);
              len     = len - 3;
              pay_off = 2'd3;
            end else begin
              pay_off = '0;
            end
            acc_len = len;
            add_beat(dbgrx_pkg::KIND_ACCEPT, 8'h00, (len > 511) ? 9'd511 : len[8:0]);
          end else begin
            add_beat(dbgrx_pkg::KIND_TX, cfg_nak, '0);
          end
        end
      endcase
    end
    if (resp_beats.size() != 0) resp_beats[resp_beats.size() - 1].last = 1'b1;
  endfunction

  task automatic report_err(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // offer one beat, with a random idle gap first; predict once it is taken
  task automatic send_item(input logic req, input logic [7:0] rx, input logic [8:0] idx,
                           input logic typed, input beat_t want);
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dbgrx_pkg::RX_TDATA_W'({idx, rx});
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
    predict_response(req, rx, idx);
    if (typed) begin
      awaited.push_back(want);
    end else begin
      foreach (resp_beats[i]) awaited.push_back(resp_beats[i]);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(dbgrx_pkg::REQ_BYTE, b, 9'($urandom_range(511)), 1'b0, NO_BEAT);
  endtask

  task automatic send_read(input logic [8:0] idx);
    send_item(dbgrx_pkg::REQ_READ, 8'($urandom_range(255)), idx, 1'b0, NO_BEAT);
  endtask

  // start char, payload, end char, two checksum digits
  task automatic send_packet(input int len, input bit want_seq, input csum_mode_t mode);
    logic [7:0] b, sum, dh, dl, junk;
    sum = '0;
    send_byte(cfg_start);
    for (int i = 0; i < len; i++) begin
      if (i == 2 && want_seq) begin
        b = {1'($urandom_range(1)), dbgrx_pkg::SEQ_SEP};
        if (b == cfg_end) b = b ^ 8'h80;
      end else if ($urandom_range(9) == 0 && cfg_start != cfg_end) begin
        b = cfg_start;
      end else begin
        do b = 8'($urandom_range(255));
        while (b == cfg_end || (i == 2 && b[6:0] == dbgrx_pkg::SEQ_SEP));
      end
      sum = sum + {1'b0, b[6:0]};
      send_byte(b);
    end
    send_byte(cfg_end);
    if (mode == CK_WRONG) sum = sum + 8'($urandom_range(1, 255));
    dh = hex_char(sum[7:4]);
    dl = hex_char(sum[3:0]);
    if (mode == CK_BAD_DIGIT) begin
      do junk = 8'($urandom_range(255)); while (digit_val(junk) >= 0);
      if ($urandom_range(1)) dh = junk;
      else dl = junk;
    end
    send_byte(dh);
    send_byte(dl);
  endtask

  // mostly well-formed packets followed by read-back, some stray reads and noise
  task automatic run_random(input int target);
    int         done, r, n, len, lim;
    csum_mode_t mode;
    done = 0;
    while (done < target) begin
      r   = $urandom_range(99);
      lim = (cfg_maxlen < dbgrx_pkg::BUF_DEPTH_DEF) ? int'(cfg_maxlen)
                                                    : dbgrx_pkg::BUF_DEPTH_DEF;
      if (r < 70) begin
        // hit the store limit now and then when it is small
        if (lim <= 16 && $urandom_range(99) < 20) len = lim + $urandom_range(1);
        else len = $urandom_range(8);
        n    = $urandom_range(99);
        mode = (n < 75) ? CK_GOOD : ((n < 90) ? CK_WRONG : CK_BAD_DIGIT);
        send_packet(len, $urandom_range(99) < 40, mode);
        n = $urandom_range(1, 3);
        repeat (n) send_read(9'($urandom_range(int'(acc_len) + 1)));
        done += len + 4 + n;
      end else if (r < 85) begin
        n = $urandom_range(1, 4);
        repeat (n) send_read(9'($urandom_range(511)));
        done += n;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(255)));
        done += n;
      end
    end
  endtask

  task automatic write_reg(input logic [dbgrx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dbgrx_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      dbgrx_pkg::REG_START_CHAR: cfg_start  = val[7:0];
      dbgrx_pkg::REG_END_CHAR:   cfg_end    = val[7:0];
      dbgrx_pkg::REG_ACK_CHAR:   cfg_ack    = val[7:0];
      dbgrx_pkg::REG_NAK_CHAR:   cfg_nak    = val[7:0];
      dbgrx_pkg::REG_MAX_LEN:    cfg_maxlen = val[dbgrx_pkg::MAXLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] st, input logic [7:0] en, input logic [7:0] ak,
                            input logic [7:0] nk, input logic [dbgrx_pkg::MAXLEN_W-1:0] ml);
    write_reg(dbgrx_pkg::REG_START_CHAR, dbgrx_pkg::CFG_DATA_W'(st));
    write_reg(dbgrx_pkg::REG_END_CHAR, dbgrx_pkg::CFG_DATA_W'(en));
    write_reg(dbgrx_pkg::REG_ACK_CHAR, dbgrx_pkg::CFG_DATA_W'(ak));
    write_reg(dbgrx_pkg::REG_NAK_CHAR, dbgrx_pkg::CFG_DATA_W'(nk));
    write_reg(dbgrx_pkg::REG_MAX_LEN, dbgrx_pkg::CFG_DATA_W'(ml));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // let every owed beat come out, then wait for bytes still in flight
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // sink side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // checker: each accepted output beat against the oldest owed beat
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_beat = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[16:8], m_axis_tlast};
      if (awaited.size() == 0) begin
        report_err($sformatf("unexpected beat kind %0d data %02h len %0d",
                             got_beat.kind, got_beat.data, got_beat.len));
      end else begin
        exp_beat = awaited.pop_front();
        if (got_beat.kind !== exp_beat.kind || got_beat.data !== exp_beat.data ||
            got_beat.len !== exp_beat.len || got_beat.last !== exp_beat.last) begin
          report_err($sformatf("kind %0d/%0d data %02h/%02h len %0d/%0d last %0d/%0d (got/exp)",
                               got_beat.kind, exp_beat.kind, got_beat.data, exp_beat.data,
                               got_beat.len, exp_beat.len, got_beat.last, exp_beat.last));
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset settings
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].req, dir_rows[i].rx, dir_rows[i].idx,
                dir_rows[i].typed, dir_rows[i].want);
    end
    drain();

    // reset settings, back to back, sink holds off long enough to stall the input
    hold_req <= hold_req + 1;
    repeat (8) send_read(9'($urandom_range(511)));
    run_random(20);
    drain();

    // start and ack chars at 0x00, end and nak chars at 0xff, one-byte store
    set_config(8'h00, 8'hff, 8'h00, 8'hff, 10'd1);
    snd_idle = 58;
    run_random(24);
    drain();

    // start and ack chars at 0xff, end and nak chars at 0x00, store limit at full depth
    set_config(8'hff, 8'h00, 8'hff, 8'h00, 10'd512);
    snd_idle  = 0;
    rcv_stall = 58;
    run_random(24);
    drain();

    // random chars, small store, light idling on both sides
    set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), 10'($urandom_range(2, 12)));
    snd_idle  = 6;
    rcv_stall = 6;
    run_random(24);
    drain();

    // random everything, no idling
    set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), 10'($urandom_range(1, 512)));
    snd_idle  = 0;
    rcv_stall = 0;
    run_random(24);
    drain();

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
